// File: sv/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg: shared types and constants for the checked frame receiver
// Beat structs, op and status codes, CSR indexes and frame marker bytes.
// ----------------------------------------------------------------------------
package cfr_pkg;

   localparam int TIMER_WIDTH_DEFAULT = 16;

   // Input beat op codes
   localparam logic [1:0] OP_BYTE  = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;

   // Verdict status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TIMEOUT   = 3'd1;
   localparam logic [2:0] ST_START     = 3'd2;
   localparam logic [2:0] ST_LENSUM    = 3'd3;
   localparam logic [2:0] ST_IDENT     = 3'd4;
   localparam logic [2:0] ST_COMMAND   = 3'd5;
   localparam logic [2:0] ST_DATASUM   = 3'd6;
   localparam logic [2:0] ST_POSTAMBLE = 3'd7;

   // Result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // CSR indexes
   localparam logic [1:0] CSR_EXPECTED_COMMAND = 2'd0;
   localparam logic [1:0] CSR_MAX_PAYLOAD      = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT_TICKS    = 2'd2;

   localparam logic [7:0]  MAX_PAYLOAD_RESET   = 8'd253;
   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;

   // Frame marker bytes
   localparam logic [7:0] MARK_PRE    = 8'h00;
   localparam logic [7:0] MARK_START2 = 8'hFF;
   localparam logic [7:0] MARK_IDENT  = 8'hD5;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_PREAMBLE,
      PH_HEADER,
      PH_TAIL
   } phase_type;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] payload_index;
      logic [7:0] payload_byte;
      logic [2:0] status;
      logic [7:0] payload_count;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  expected_command;
      logic [7:0]  max_payload;
      logic [15:0] timeout_ticks;
   } cfg_type;

endpackage

// File: sv/cfr_csr.sv
// ----------------------------------------------------------------------------
// cfr_csr: configuration registers
// Write-only register file; out-of-range indexes are dropped.
// ----------------------------------------------------------------------------
module cfr_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_en,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata,
   output cfr_pkg::cfg_type cfg
);

   cfr_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_command <= 8'd0;
         cfg_ff.max_payload      <= cfr_pkg::MAX_PAYLOAD_RESET;
         cfg_ff.timeout_ticks    <= cfr_pkg::TIMEOUT_TICKS_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            cfr_pkg::CSR_EXPECTED_COMMAND: cfg_ff.expected_command <= csr_wdata[7:0];
            cfr_pkg::CSR_MAX_PAYLOAD:      cfg_ff.max_payload      <= csr_wdata[7:0];
            cfr_pkg::CSR_TIMEOUT_TICKS:    cfg_ff.timeout_ticks    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/cfr_frame_fsm.sv
// ----------------------------------------------------------------------------
// cfr_frame_fsm: frame parsing state machine
// Consumes one beat per advance, updates frame state and forms the result.
// ----------------------------------------------------------------------------
module cfr_frame_fsm #(
   parameter int TIMER_WIDTH = cfr_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  cfr_pkg::req_type req,
   input  cfr_pkg::cfg_type cfg,
   output logic             emit,
   output cfr_pkg::rsp_type rsp
);

   localparam int LW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

   localparam logic [2:0] HDR_START1 = 3'd0;
   localparam logic [2:0] HDR_START2 = 3'd1;
   localparam logic [2:0] HDR_LENGTH = 3'd2;
   localparam logic [2:0] HDR_LENSUM = 3'd3;
   localparam logic [2:0] HDR_IDENT  = 3'd4;
   localparam logic [2:0] HDR_CMD    = 3'd5;

   cfr_pkg::phase_type     phase_ff, phase_in;
   logic [2:0]             header_count_ff, header_count_in;
   logic                   start_bad_ff, start_bad_in;
   logic [7:0]             frame_length_ff, frame_length_in;
   logic [7:0]             length_check_ff, length_check_in;
   logic [7:0]             frame_ident_ff, frame_ident_in;
   logic [7:0]             tail_count_ff, tail_count_in;
   logic [7:0]             running_sum_ff, running_sum_in;
   logic [7:0]             checksum_seen_ff, checksum_seen_in;
   logic [TIMER_WIDTH-1:0] tick_count_ff, tick_count_in;

   logic [TIMER_WIDTH-1:0] tick_next;
   logic [LW-1:0]          tmax_w, limit_w;
   logic [7:0]             plen, b, len_sum, data_sum;
   logic [8:0]             cmd_expect;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= cfr_pkg::PH_IDLE;
         header_count_ff  <= 3'd0;
         start_bad_ff     <= 1'b0;
         frame_length_ff  <= 8'd0;
         length_check_ff  <= 8'd0;
         frame_ident_ff   <= 8'd0;
         tail_count_ff    <= 8'd0;
         running_sum_ff   <= 8'd0;
         checksum_seen_ff <= 8'd0;
         tick_count_ff    <= '0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         header_count_ff  <= header_count_in;
         start_bad_ff     <= start_bad_in;
         frame_length_ff  <= frame_length_in;
         length_check_ff  <= length_check_in;
         frame_ident_ff   <= frame_ident_in;
         tail_count_ff    <= tail_count_in;
         running_sum_ff   <= running_sum_in;
         checksum_seen_ff <= checksum_seen_in;
         tick_count_ff    <= tick_count_in;
      end
   end

   always_comb begin
      b          = req.rx_byte;
      tmax_w     = LW'({TIMER_WIDTH{1'b1}});
      limit_w    = (LW'(cfg.timeout_ticks) > tmax_w) ? tmax_w : LW'(cfg.timeout_ticks);
      tick_next  = (tick_count_ff == '1) ? tick_count_ff : tick_count_ff + 1'b1;
      plen       = (frame_length_ff >= 8'd2) ? frame_length_ff - 8'd2 : 8'd0;
      len_sum    = frame_length_ff + length_check_ff;
      data_sum   = running_sum_ff + checksum_seen_ff;
      cmd_expect = {1'b0, cfg.expected_command} + 9'd1;

      phase_in         = phase_ff;
      header_count_in  = header_count_ff;
      start_bad_in     = start_bad_ff;
      frame_length_in  = frame_length_ff;
      length_check_in  = length_check_ff;
      frame_ident_in   = frame_ident_ff;
      tail_count_in    = tail_count_ff;
      running_sum_in   = running_sum_ff;
      checksum_seen_in = checksum_seen_ff;
      tick_count_in    = tick_count_ff;

      emit              = 1'b0;
      rsp.kind          = cfr_pkg::KIND_VERDICT;
      rsp.payload_index = 8'd0;
      rsp.payload_byte  = 8'd0;
      rsp.status        = cfr_pkg::ST_OK;
      rsp.payload_count = 8'd0;

      case (req.op)
         cfr_pkg::OP_START: begin
            phase_in         = cfr_pkg::PH_PREAMBLE;
            header_count_in  = 3'd0;
            start_bad_in     = 1'b0;
            tail_count_in    = 8'd0;
            running_sum_in   = 8'd0;
            checksum_seen_in = 8'd0;
            tick_count_in    = '0;
         end
         cfr_pkg::OP_TICK: begin
            if (phase_ff != cfr_pkg::PH_IDLE) begin
               tick_count_in = tick_next;
               if (LW'(tick_next) >= limit_w) begin
                  emit       = 1'b1;
                  rsp.status = cfr_pkg::ST_TIMEOUT;
                  phase_in   = cfr_pkg::PH_IDLE;
               end
            end
         end
         cfr_pkg::OP_BYTE: begin
            case (phase_ff)
               cfr_pkg::PH_PREAMBLE: begin
                  if (b == cfr_pkg::MARK_PRE) begin
                     phase_in        = cfr_pkg::PH_HEADER;
                     header_count_in = 3'd0;
                     start_bad_in    = 1'b0;
                     tick_count_in   = '0;
                  end
               end
               cfr_pkg::PH_HEADER: begin
                  header_count_in = header_count_ff + 3'd1;
                  case (header_count_ff)
                     HDR_START1: start_bad_in = start_bad_ff | (b != cfr_pkg::MARK_PRE);
                     HDR_START2: start_bad_in = start_bad_ff | (b != cfr_pkg::MARK_START2);
                     HDR_LENGTH: frame_length_in = b;
                     HDR_LENSUM: length_check_in = b;
                     HDR_IDENT:  frame_ident_in  = b;
                     default: begin
                        // last header byte: response command, run the checks
                        if (header_count_ff >= HDR_CMD) begin
                           emit     = 1'b1;
                           phase_in = cfr_pkg::PH_IDLE;
                           if (start_bad_ff) begin
                              rsp.status = cfr_pkg::ST_START;
                           end else if (len_sum != 8'd0) begin
                              rsp.status = cfr_pkg::ST_LENSUM;
                           end else if (frame_ident_ff != cfr_pkg::MARK_IDENT) begin
                              rsp.status = cfr_pkg::ST_IDENT;
                           end else if ({1'b0, b} != cmd_expect) begin
                              rsp.status = cfr_pkg::ST_COMMAND;
                           end else begin
                              emit             = 1'b0;
                              phase_in         = cfr_pkg::PH_TAIL;
                              tail_count_in    = 8'd0;
                              running_sum_in   = frame_ident_ff + b;
                              checksum_seen_in = 8'd0;
                              tick_count_in    = '0;
                           end
                        end
                     end
                  endcase
               end
               cfr_pkg::PH_TAIL: begin
                  tail_count_in = tail_count_ff + 8'd1;
                  if (tail_count_ff < plen) begin
                     running_sum_in = running_sum_ff + b;
                     if (tail_count_ff < cfg.max_payload) begin
                        emit              = 1'b1;
                        rsp.kind          = cfr_pkg::KIND_PAYLOAD;
                        rsp.payload_index = tail_count_ff;
                        rsp.payload_byte  = b;
                     end
                  end else if (tail_count_ff == plen) begin
                     checksum_seen_in = b;
                  end else begin
                     emit     = 1'b1;
                     phase_in = cfr_pkg::PH_IDLE;
                     if (data_sum != 8'd0) begin
                        rsp.status = cfr_pkg::ST_DATASUM;
                     end else if (b != cfr_pkg::MARK_PRE) begin
                        rsp.status = cfr_pkg::ST_POSTAMBLE;
                     end else begin
                        rsp.payload_count = (plen < cfg.max_payload) ? plen : cfg.max_payload;
                     end
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

endmodule

// File: sv/checked_frame_receiver_top.sv
// Beats are registered in the input register, results in the result register.
// Throughput: one input beat per cycle unless the result register is stalled.
// Result register acts as the output stage; input stalls only while it is full
// and not being taken.
// Reset: synchronous, active high; clears the frame state to idle and loads
// the CSR reset values (max_payload 253, timeout_ticks 1000).
// ----------------------------------------------------------------------------
// checked_frame_receiver_top: checked frame receiver
// Parses preamble, header, payload and tail of a byte stream, forwards up to
// max_payload payload bytes and ends each frame with one verdict beat.
// ----------------------------------------------------------------------------
module checked_frame_receiver_top #(
   parameter int TIMER_WIDTH = cfr_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_ready,
   input  cfr_pkg::req_type req_data,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cfr_pkg::rsp_type rsp_data,
   // CSR write port
   input  logic             csr_write_en,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);

   cfr_pkg::cfg_type cfg;

   // input register
   cfr_pkg::req_type req_ff;
   logic             req_valid_ff;

   // result register
   cfr_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff;
   logic             emit;

   logic             out_free;
   logic             advance;

   // The held beat moves on when the result register can take its result.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = req_valid_ff && out_free;
   assign req_ready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_ff <= req_data;
      end
   end

   cfr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   cfr_frame_fsm #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_fsm (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (req_ff),
      .cfg     (cfg),
      .emit    (emit),
      .rsp     (rsp_in)
   );

   // Result register: loaded on advance (only if a result is made), else
   // drained by the consumer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
